@@ src/ntc_pkg.sv @@
package ntc_pkg;

   localparam int NUM_TEMPLATES_DEF   = 6;
   localparam int TEMPLATE_PIXELS_DEF = 2048;

   localparam int SLOT_W  = 3;
   localparam int PIX_W   = 11;
   localparam int CHAN_W  = 8;
   localparam int TILE_W  = 4;
   localparam int CLASS_W = 3;
   localparam int LIMIT_W = 19;
   localparam int SUM_W   = 20;
   localparam int GAP_W   = 10;
   localparam int TPL_W   = 3 * CHAN_W;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET   = LIMIT_W'(40000);
   localparam logic [CLASS_W-1:0] UNKNOWN_CLASS = CLASS_W'(6);
   localparam logic [SUM_W-1:0]   SUM_MAX       = {SUM_W{1'b1}};

   // x / 3 == (x * 683) >> 11 for every x below 1024
   localparam int DIV3_MUL   = 683;
   localparam int DIV3_SHIFT = 11;
   localparam int PROD_W     = GAP_W + GAP_W;

   localparam logic FUNC_LOAD   = 1'b0;
   localparam logic FUNC_SCREEN = 1'b1;

   localparam int CSR_ADDR_W      = 3;
   localparam logic CSR_MATCH_LIMIT = 1'b0;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   typedef struct packed {
      logic              load_we;
      logic              screen;
      logic              in_range;
      logic              last;
      logic [SLOT_W-1:0] slot;
      logic [PIX_W-1:0]  pix;
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic [TILE_W-1:0] col;
      logic [TILE_W-1:0] row;
   } item_type;

endpackage

@@ src/nearest_template_tile_classifier_unit.sv @@
// Tile classifier against a store of RGB templates.
// Request words either load one template pixel (func low, slot and pixel
// index select the entry) or carry one screen pixel of a tile window (func
// high). Screen pixels stream in raster order; every template keeps a
// running sum of a third of the per-pixel color gap. The word with last set
// closes the window and yields one response word: the closest template whose
// sum is below match_limit, or unknown. Load words yield nothing.
// Throughput is one request word per cycle while req_stall is low; every template has its own
// memory bank and accumulator, so all banks are read in the same cycle.
// From an accepted last word to rsp_valid the window passes the queue, bank
// read, gap, accumulate, select and output register; rsp_stall can hold it.
// A four-word queue sits between the request side and the datapath, so
// request words are still taken while a response waits; once rsp_stall holds
// the datapath and the queue fills, req_stall rises.
// Reset empties the queue, clears the sums and loads match_limit with its
// default; template contents are undefined until loaded.
// match_limit sits at byte address 0 of the register port.
module nearest_template_tile_classifier_unit import ntc_pkg::*; #(
   parameter int NUM_TEMPLATES   = NUM_TEMPLATES_DEF,
   parameter int TEMPLATE_PIXELS = TEMPLATE_PIXELS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_func,
   input  logic [SLOT_W-1:0]     req_template_slot,
   input  logic [PIX_W-1:0]      req_pixel_index,
   input  logic [CHAN_W-1:0]     req_red,
   input  logic [CHAN_W-1:0]     req_green,
   input  logic [CHAN_W-1:0]     req_blue,
   input  logic                  req_last,
   input  logic [TILE_W-1:0]     req_tile_col,
   input  logic [TILE_W-1:0]     req_tile_row,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [CLASS_W-1:0]    rsp_tile_class,
   output logic [LIMIT_W-1:0]    rsp_best_diff,
   output logic                  rsp_found,
   output logic [TILE_W-1:0]     rsp_tile_col_out,
   output logic [TILE_W-1:0]     rsp_tile_row_out,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   logic [LIMIT_W-1:0] match_limit_ff;
   logic               csr_write;
   item_type           head_item;
   logic               head_valid;
   logic               pop;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         match_limit_ff <= LIMIT_RESET;
      end else if (csr_write && (paddr[2] == CSR_MATCH_LIMIT)) begin
         match_limit_ff <= pwdata[LIMIT_W-1:0];
      end
   end

   assign prdata = (paddr[2] == CSR_MATCH_LIMIT) ? 32'(match_limit_ff) : '0;

   ntc_front #(
      .NUM_TEMPLATES   (NUM_TEMPLATES),
      .TEMPLATE_PIXELS (TEMPLATE_PIXELS)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_func          (req_func),
      .req_template_slot (req_template_slot),
      .req_pixel_index   (req_pixel_index),
      .req_red           (req_red),
      .req_green         (req_green),
      .req_blue          (req_blue),
      .req_last          (req_last),
      .req_tile_col      (req_tile_col),
      .req_tile_row      (req_tile_row),
      .head_item         (head_item),
      .head_valid        (head_valid),
      .pop               (pop)
   );

   ntc_back #(
      .NUM_TEMPLATES   (NUM_TEMPLATES),
      .TEMPLATE_PIXELS (TEMPLATE_PIXELS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .head_item        (head_item),
      .head_valid       (head_valid),
      .pop              (pop),
      .match_limit      (match_limit_ff),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_tile_class   (rsp_tile_class),
      .rsp_best_diff    (rsp_best_diff),
      .rsp_found        (rsp_found),
      .rsp_tile_col_out (rsp_tile_col_out),
      .rsp_tile_row_out (rsp_tile_row_out)
   );

endmodule

@@ src/ntc_front.sv @@
module ntc_front import ntc_pkg::*; #(
   parameter int NUM_TEMPLATES   = NUM_TEMPLATES_DEF,
   parameter int TEMPLATE_PIXELS = TEMPLATE_PIXELS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_func,
   input  logic [SLOT_W-1:0] req_template_slot,
   input  logic [PIX_W-1:0]  req_pixel_index,
   input  logic [CHAN_W-1:0] req_red,
   input  logic [CHAN_W-1:0] req_green,
   input  logic [CHAN_W-1:0] req_blue,
   input  logic              req_last,
   input  logic [TILE_W-1:0] req_tile_col,
   input  logic [TILE_W-1:0] req_tile_row,
   output item_type          head_item,
   output logic              head_valid,
   input  logic              pop
);

   item_type            item_in;
   item_type            q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QCNT_W-1:0]   count_ff;
   logic [QCNT_W-1:0]   count_in;
   logic                full;
   logic                push;
   logic                pop_ok;
   logic                pix_ok;
   logic                slot_ok;

   always_comb begin
      pix_ok           = 32'(req_pixel_index) < TEMPLATE_PIXELS;
      slot_ok          = 32'(req_template_slot) < NUM_TEMPLATES;
      item_in.load_we  = (req_func == FUNC_LOAD) && pix_ok && slot_ok;
      item_in.screen   = (req_func == FUNC_SCREEN);
      item_in.in_range = pix_ok;
      item_in.last     = (req_func == FUNC_SCREEN) && req_last;
      item_in.slot     = req_template_slot;
      item_in.pix      = req_pixel_index;
      item_in.red      = req_red;
      item_in.green    = req_green;
      item_in.blue     = req_blue;
      item_in.col      = req_tile_col;
      item_in.row      = req_tile_row;
   end

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign req_stall  = full;
   assign push       = req_valid && !full;
   assign head_valid = (count_ff != '0);
   assign pop_ok     = pop && head_valid;
   assign head_item  = q_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop_ok) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop_ok && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop_ok) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= item_in;
      end
   end

endmodule

@@ src/ntc_back.sv @@
module ntc_back import ntc_pkg::*; #(
   parameter int NUM_TEMPLATES   = NUM_TEMPLATES_DEF,
   parameter int TEMPLATE_PIXELS = TEMPLATE_PIXELS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  item_type           head_item,
   input  logic               head_valid,
   output logic               pop,
   input  logic [LIMIT_W-1:0] match_limit,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [CLASS_W-1:0] rsp_tile_class,
   output logic [LIMIT_W-1:0] rsp_best_diff,
   output logic               rsp_found,
   output logic [TILE_W-1:0]  rsp_tile_col_out,
   output logic [TILE_W-1:0]  rsp_tile_row_out
);

   localparam int ADDR_W  = (TEMPLATE_PIXELS > 1) ? $clog2(TEMPLATE_PIXELS) : 1;
   localparam int IDX_W   = (NUM_TEMPLATES > 1) ? $clog2(NUM_TEMPLATES) : 1;
   localparam int TREE_LV = $clog2(NUM_TEMPLATES);
   localparam int TREE_N  = 2 ** TREE_LV;

   logic               advance;
   logic [ADDR_W-1:0]  addr;
   logic               rd_en;
   logic               s1_valid_ff;
   item_type           s1_item_ff;
   logic               s2_valid_ff;
   item_type           s2_item_ff;
   logic               s3_valid_ff;
   item_type           s3_item_ff;
   logic [CHAN_W-1:0]  gap_d [NUM_TEMPLATES];
   logic [SUM_W-1:0]   sums_ff [NUM_TEMPLATES];
   logic [SUM_W-1:0]   sums_in [NUM_TEMPLATES];
   logic [SUM_W-1:0]   final_ff [NUM_TEMPLATES];
   logic [SUM_W:0]     acc;
   logic               s2_add;
   logic               s2_close;
   logic [SUM_W-1:0]   node_val [TREE_LV+1][TREE_N];
   logic [IDX_W-1:0]   node_idx [TREE_LV+1][TREE_N];
   logic               node_hit [TREE_LV+1][TREE_N];
   logic               take_b;
   logic               rsp_valid_ff;
   logic [CLASS_W-1:0] tile_class_ff;
   logic [LIMIT_W-1:0] best_diff_ff;
   logic               found_ff;
   logic [TILE_W-1:0]  col_ff;
   logic [TILE_W-1:0]  row_ff;

   assign advance = !(rsp_valid_ff && rsp_stall);
   assign pop     = advance && head_valid;
   assign addr    = ADDR_W'(head_item.pix);
   assign rd_en   = pop && head_item.screen && head_item.in_range;

   for (genvar t = 0; t < NUM_TEMPLATES; t++) begin : g_lane
      logic [TPL_W-1:0]  mem [TEMPLATE_PIXELS];
      logic [TPL_W-1:0]  rd_ff;
      logic [CHAN_W-1:0] d_ff;
      logic [CHAN_W-1:0] tr;
      logic [CHAN_W-1:0] tg;
      logic [CHAN_W-1:0] tb;
      logic [CHAN_W-1:0] ar;
      logic [CHAN_W-1:0] ag;
      logic [CHAN_W-1:0] ab;
      logic [GAP_W-1:0]  gap;
      logic [PROD_W-1:0] prod;
      logic              we;

      assign we = pop && head_item.load_we && (32'(head_item.slot) == t);

      always_ff @(posedge clock) begin
         if (we) begin
            mem[addr] <= {head_item.red, head_item.green, head_item.blue};
         end
         if (rd_en) begin
            rd_ff <= mem[addr];
         end
      end

      always_comb begin
         tr   = rd_ff[TPL_W-1 -: CHAN_W];
         tg   = rd_ff[CHAN_W +: CHAN_W];
         tb   = rd_ff[CHAN_W-1:0];
         ar   = (tr > s1_item_ff.red)   ? tr - s1_item_ff.red   : s1_item_ff.red - tr;
         ag   = (tg > s1_item_ff.green) ? tg - s1_item_ff.green : s1_item_ff.green - tg;
         ab   = (tb > s1_item_ff.blue)  ? tb - s1_item_ff.blue  : s1_item_ff.blue - tb;
         gap  = GAP_W'(ar) + GAP_W'(ag) + GAP_W'(ab);
         prod = PROD_W'(gap) * PROD_W'(DIV3_MUL);
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            d_ff <= prod[DIV3_SHIFT +: CHAN_W];
         end
      end

      assign gap_d[t] = d_ff;
   end

   assign s2_add   = s2_valid_ff && s2_item_ff.screen && s2_item_ff.in_range;
   assign s2_close = s2_valid_ff && s2_item_ff.last;

   always_comb begin
      acc = '0;
      for (int t = 0; t < NUM_TEMPLATES; t++) begin
         acc        = {1'b0, sums_ff[t]} + (SUM_W+1)'(gap_d[t]);
         sums_in[t] = sums_ff[t];
         if (s2_add) begin
            sums_in[t] = acc[SUM_W] ? SUM_MAX : acc[SUM_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         for (int t = 0; t < NUM_TEMPLATES; t++) begin
            sums_ff[t] <= '0;
         end
      end else if (advance) begin
         s1_valid_ff <= pop;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_close;
         for (int t = 0; t < NUM_TEMPLATES; t++) begin
            sums_ff[t] <= s2_close ? '0 : sums_in[t];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_item_ff <= head_item;
         s2_item_ff <= s1_item_ff;
         s3_item_ff <= s2_item_ff;
         if (s2_close) begin
            for (int t = 0; t < NUM_TEMPLATES; t++) begin
               final_ff[t] <= sums_in[t];
            end
         end
      end
   end

   always_comb begin
      take_b = 1'b0;
      for (int l = 0; l <= TREE_LV; l++) begin
         for (int i = 0; i < TREE_N; i++) begin
            node_val[l][i] = '0;
            node_idx[l][i] = '0;
            node_hit[l][i] = 1'b0;
         end
      end
      for (int i = 0; i < NUM_TEMPLATES; i++) begin
         node_val[0][i] = final_ff[i];
         node_idx[0][i] = IDX_W'(i);
         node_hit[0][i] = final_ff[i] < SUM_W'(match_limit);
      end
      for (int l = 1; l <= TREE_LV; l++) begin
         for (int i = 0; i < (TREE_N >> l); i++) begin
            take_b = node_hit[l-1][2*i+1] &&
                     (!node_hit[l-1][2*i] ||
                      (node_val[l-1][2*i+1] < node_val[l-1][2*i]));
            node_val[l][i] = take_b ? node_val[l-1][2*i+1] : node_val[l-1][2*i];
            node_idx[l][i] = take_b ? node_idx[l-1][2*i+1] : node_idx[l-1][2*i];
            node_hit[l][i] = take_b ? node_hit[l-1][2*i+1] : node_hit[l-1][2*i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         found_ff      <= node_hit[TREE_LV][0];
         tile_class_ff <= node_hit[TREE_LV][0] ? CLASS_W'(node_idx[TREE_LV][0])
                                               : UNKNOWN_CLASS;
         best_diff_ff  <= node_hit[TREE_LV][0] ? LIMIT_W'(node_val[TREE_LV][0])
                                               : '0;
         col_ff        <= s3_item_ff.col;
         row_ff        <= s3_item_ff.row;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_tile_class   = tile_class_ff;
   assign rsp_best_diff    = best_diff_ff;
   assign rsp_found        = found_ff;
   assign rsp_tile_col_out = col_ff;
   assign rsp_tile_row_out = row_ff;

endmodule
